// ===== src/cot_pkg.sv =====
package cot_pkg;

	localparam int NUM_FACES = 6;
	localparam int FACE_W    = 3;

	typedef logic [FACE_W-1:0] face_t;
	typedef face_t [NUM_FACES-1:0] map_t;

	// face encoding
	localparam face_t FACE_F = 3'd0;
	localparam face_t FACE_R = 3'd1;
	localparam face_t FACE_U = 3'd2;
	localparam face_t FACE_B = 3'd3;
	localparam face_t FACE_L = 3'd4;
	localparam face_t FACE_D = 3'd5;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [1:0] {
		TURN_NONE = 2'd0,
		TURN_P90  = 2'd1,
		TURN_180  = 2'd2,
		TURN_M90  = 2'd3
	} turn_t;

	// floor(x / 90) = (x * RECIP_90) >> RECIP_SHIFT, exact for x <= 32768
	localparam int ANGLE_W     = 16;
	localparam int QUO_W       = 10;
	localparam int RECIP_SHIFT = 22;
	localparam logic [ANGLE_W-1:0] RECIP_90 = 16'd46604;

endpackage

// ===== src/cot_angle_decode.sv =====
module cot_angle_decode (
	input  logic signed [15:0] angle,
	output cot_pkg::turn_t     turn
);
	import cot_pkg::*;

	logic                  neg;
	logic [ANGLE_W-1:0]    mag;
	logic [2*ANGLE_W-1:0]  prod;
	logic [QUO_W-1:0]      quo;
	logic [ANGLE_W:0]      back;
	logic                  exact;
	logic [1:0]            quarter;

	// remainder toward zero: work on the magnitude, then fold the sign back in
	assign neg  = angle[15];
	assign mag  = neg ? (~$unsigned(angle) + 16'd1) : $unsigned(angle);
	assign prod = {16'd0, mag} * {16'd0, RECIP_90};
	assign quo  = prod[RECIP_SHIFT +: QUO_W];

	// 90 * quo as shifts and adds
	assign back = ({7'd0, quo} << 6) + ({7'd0, quo} << 4) + ({7'd0, quo} << 3)
		+ ({7'd0, quo} << 1);
	assign exact = (back == {1'b0, mag});

	// quarter turns mod 4, negated for negative angles
	assign quarter = neg ? (2'd0 - quo[1:0]) : quo[1:0];

	always_comb begin
		turn = TURN_NONE;
		if (exact) begin
			unique case (quarter)
				2'd0: turn = TURN_NONE;
				2'd1: turn = TURN_P90;
				2'd2: turn = TURN_180;
				2'd3: turn = TURN_M90;
				default: turn = TURN_NONE;
			endcase
		end
	end

endmodule

// ===== src/cot_rotate.sv =====
module cot_rotate (
	input  cot_pkg::axis_t axis,
	input  cot_pkg::turn_t turn,
	input  cot_pkg::map_t  map_in,
	output cot_pkg::map_t  map_out
);
	import cot_pkg::*;

	always_comb begin
		map_out = map_in;
		unique case (axis)
			AXIS_X: begin
				unique case (turn)
					TURN_P90: begin
						map_out[FACE_U] = map_in[FACE_F];
						map_out[FACE_F] = map_in[FACE_D];
						map_out[FACE_D] = map_in[FACE_B];
						map_out[FACE_B] = map_in[FACE_U];
					end
					TURN_M90: begin
						map_out[FACE_U] = map_in[FACE_B];
						map_out[FACE_B] = map_in[FACE_D];
						map_out[FACE_D] = map_in[FACE_F];
						map_out[FACE_F] = map_in[FACE_U];
					end
					TURN_180: begin
						map_out[FACE_U] = map_in[FACE_D];
						map_out[FACE_D] = map_in[FACE_U];
						map_out[FACE_F] = map_in[FACE_B];
						map_out[FACE_B] = map_in[FACE_F];
					end
					TURN_NONE: map_out = map_in;
				endcase
			end
			AXIS_Y: begin
				unique case (turn)
					TURN_P90: begin
						map_out[FACE_F] = map_in[FACE_L];
						map_out[FACE_L] = map_in[FACE_B];
						map_out[FACE_B] = map_in[FACE_R];
						map_out[FACE_R] = map_in[FACE_F];
					end
					TURN_M90: begin
						map_out[FACE_F] = map_in[FACE_R];
						map_out[FACE_R] = map_in[FACE_B];
						map_out[FACE_B] = map_in[FACE_L];
						map_out[FACE_L] = map_in[FACE_F];
					end
					TURN_180: begin
						map_out[FACE_F] = map_in[FACE_B];
						map_out[FACE_B] = map_in[FACE_F];
						map_out[FACE_R] = map_in[FACE_L];
						map_out[FACE_L] = map_in[FACE_R];
					end
					TURN_NONE: map_out = map_in;
				endcase
			end
			AXIS_Z: begin
				unique case (turn)
					TURN_P90: begin
						map_out[FACE_U] = map_in[FACE_R];
						map_out[FACE_R] = map_in[FACE_D];
						map_out[FACE_D] = map_in[FACE_L];
						map_out[FACE_L] = map_in[FACE_U];
					end
					TURN_M90: begin
						map_out[FACE_U] = map_in[FACE_L];
						map_out[FACE_L] = map_in[FACE_D];
						map_out[FACE_D] = map_in[FACE_R];
						map_out[FACE_R] = map_in[FACE_U];
					end
					TURN_180: begin
						map_out[FACE_U] = map_in[FACE_D];
						map_out[FACE_D] = map_in[FACE_U];
						map_out[FACE_R] = map_in[FACE_L];
						map_out[FACE_L] = map_in[FACE_R];
					end
					TURN_NONE: map_out = map_in;
				endcase
			end
			default: map_out = map_in;
		endcase
	end

endmodule

// ===== src/cube_orientation_tracker.sv =====
// cube orientation tracker
// keeps a six-entry map from logical cube faces to the physical faces they
// now occupy; faces are coded 0 F, 1 R, 2 U, 3 B, 4 L, 5 D
// input stream (s_axis): one word per item; tuser[0] picks the kind
// (0 rotate the whole cube by the x, y, z angles, 1 map a logical move)
// output stream (m_axis): one word per input word, carrying the mapped
// move face and suffix and the full map as it stands after the item
// path: a word accepted on s_axis goes into the input register, then into
// the result register, and is offered on m_axis from there
// throughput: one word per cycle while m_axis is not stalled; the map update is a single pass of
// three angle decoders and three cascaded permutation stages
// reset: the map returns to identity and both pipeline registers empty
// stall: while a result word waits with m_axis_tready low the result register holds; one more
// word can sit in the input register, after that s_axis_tready drops
module cube_orientation_tracker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// angle_x[15:0], angle_y[31:16], angle_z[47:32], move_face[50:48],
	// move_suffix[58:51], zero pad[63:59]
	input  logic [63:0] s_axis_tdata,
	// kind[0], move_has_suffix[1]
	input  logic [1:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_face[2:0], out_suffix[10:3], map_front[13:11], map_right[16:14],
	// map_up[19:17], map_back[22:20], map_left[25:23], map_down[28:26],
	// zero pad[31:29]
	output logic [31:0] m_axis_tdata,
	// out_has_suffix[0]
	output logic [0:0]  m_axis_tuser
);
	import cot_pkg::*;

	// input register
	logic               valid_s1;
	logic               kind_s1;
	logic signed [15:0] angle_x_s1;
	logic signed [15:0] angle_y_s1;
	logic signed [15:0] angle_z_s1;
	face_t              face_s1;
	logic [7:0]         suffix_s1;
	logic               has_s1;

	// result register and map state
	logic               out_valid_q;
	face_t              out_face_q;
	logic [7:0]         out_suffix_q;
	logic               out_has_q;
	map_t               out_map_q;
	map_t               map_q;

	logic               in_accept;
	logic               advance;

	turn_t              turn_x;
	turn_t              turn_y;
	turn_t              turn_z;
	map_t               map_x;
	map_t               map_y;
	map_t               map_z;
	map_t               map_next;
	face_t              face_res;
	logic [7:0]         suffix_res;
	logic               has_res;

	// the input stage moves on whenever the result register is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1    <= s_axis_tuser[0];
			has_s1     <= s_axis_tuser[1];
			angle_x_s1 <= $signed(s_axis_tdata[15:0]);
			angle_y_s1 <= $signed(s_axis_tdata[31:16]);
			angle_z_s1 <= $signed(s_axis_tdata[47:32]);
			face_s1    <= s_axis_tdata[50:48];
			suffix_s1  <= s_axis_tdata[58:51];
		end
	end

	// whole-cube turn: x, then y, then z, each on the map left by the previous
	cot_angle_decode u_dec_x (.angle(angle_x_s1), .turn(turn_x));
	cot_angle_decode u_dec_y (.angle(angle_y_s1), .turn(turn_y));
	cot_angle_decode u_dec_z (.angle(angle_z_s1), .turn(turn_z));

	cot_rotate u_rot_x (.axis(AXIS_X), .turn(turn_x), .map_in(map_q), .map_out(map_x));
	cot_rotate u_rot_y (.axis(AXIS_Y), .turn(turn_y), .map_in(map_x), .map_out(map_y));
	cot_rotate u_rot_z (.axis(AXIS_Z), .turn(turn_z), .map_in(map_y), .map_out(map_z));

	assign map_next = kind_s1 ? map_q : map_z;

	// move lookup; faces 6 and 7, and moves without a suffix, pass through unmapped
	always_comb begin
		face_res   = '0;
		suffix_res = '0;
		has_res    = 1'b0;
		if (kind_s1) begin
			if (!has_s1) begin
				face_res = face_s1;
			end else begin
				face_res   = (face_s1 < FACE_W'(NUM_FACES)) ? map_q[face_s1] : face_s1;
				suffix_res = suffix_s1;
				has_res    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_FACES; i++) begin
				map_q[i] <= FACE_W'(i);
			end
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				map_q       <= map_next;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_face_q   <= face_res;
			out_suffix_q <= suffix_res;
			out_has_q    <= has_res;
			out_map_q    <= map_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_has_q;
	assign m_axis_tdata  = {3'd0,
		out_map_q[FACE_D], out_map_q[FACE_L], out_map_q[FACE_B],
		out_map_q[FACE_U], out_map_q[FACE_R], out_map_q[FACE_F],
		out_suffix_q, out_face_q};

endmodule

// ===== src/cot_checker.sv =====
module cot_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// each input accept must be followed by m_axis_tvalid on the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
		else $error("output word missing after input accept");

	// map entries stay valid face codes
	a_map_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		m_axis_tdata[13:11] <= 3'd5 && m_axis_tdata[16:14] <= 3'd5 &&
		m_axis_tdata[19:17] <= 3'd5 && m_axis_tdata[22:20] <= 3'd5 &&
		m_axis_tdata[25:23] <= 3'd5 && m_axis_tdata[28:26] <= 3'd5)
		else $error("map entry out of range");

	// no suffix flag means a cleared suffix byte
	a_suffix_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[10:3] == 8'd0)
		else $error("suffix byte set without suffix flag");

endmodule

bind cube_orientation_tracker cot_checker u_cot_checker (.*);
